@@ src/drps_pkg.sv @@
// Shared types and constants for the dead reckoning pose step unit.
package drps_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TURN,
      ST_SPEED,
      ST_DIST,
      ST_DACC,
      ST_MOD,
      ST_FOLD,
      ST_QUAD,
      ST_CORDIC,
      ST_MULX,
      ST_MULY,
      ST_DIVX,
      ST_DIVY,
      ST_YACC,
      ST_OUT
   } drps_state_type;

   // Status of the iterative rotator
   typedef struct packed {
      logic busy;
      logic done;
   } cordic_status_type;

   // Shared multiplier operand and product
   typedef logic signed [32:0] mul_opnd_type;
   typedef logic signed [65:0] mul_prod_type;

   // Heading limits in Q9.16 degrees, sized for the widened heading sum
   localparam logic signed [26:0] DEG_360 = 27'sd23592960;
   localparam logic signed [26:0] DEG_180 = 27'sd11796480;
   localparam logic signed [26:0] DEG_90  = 27'sd5898240;

   // Exact divide by 25 for 22-bit dividends: q = (n * MAGIC) >> SHIFT
   localparam logic [22:0] DIV25_MAGIC = 23'd5368710;
   localparam int          DIV25_SHIFT = 27;
   localparam int          QUOT_W      = 18;
   localparam int          DIVIDEND_W  = 22;

   // Rotator setup: 16 iterations, angle in 2^-24 degree, vectors in Q2.30
   localparam int CORDIC_ITERS = 16;
   localparam int ITER_W       = 4;
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

   localparam logic signed [31:0] ATAN_DEG_Q24 [CORDIC_ITERS] = '{
      32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
      32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
      32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
      32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335
   };

endpackage

@@ src/drps_if.sv @@
// Valid/ready channels for step words and pose words.
interface drps_req_if;
   logic                valid;
   logic                ready;
   logic        [15:0]  step_length;
   logic signed [15:0]  speed;
   logic signed [15:0]  turn_rate;

   modport source (output valid, step_length, speed, turn_rate, input ready);
   modport sink   (input valid, step_length, speed, turn_rate, output ready);
endinterface

interface drps_rsp_if;
   logic                valid;
   logic                ready;
   logic        [31:0]  elapsed_time;
   logic signed [25:0]  heading_out;
   logic signed [31:0]  distance_out;
   logic signed [31:0]  x_out;
   logic signed [31:0]  y_out;

   modport source (output valid, elapsed_time, heading_out, distance_out, x_out, y_out,
                   input ready);
   modport sink   (input valid, elapsed_time, heading_out, distance_out, x_out, y_out,
                   output ready);
endinterface

@@ src/drps_mul.sv @@
// Shared signed multiplier with registered product.
module drps_mul
   import drps_pkg::*;
(
   input  logic         clock,
   input  mul_opnd_type op_a,
   input  mul_opnd_type op_b,
   output mul_prod_type prod_ff
);

   // Register the product every cycle
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

@@ src/drps_cordic.sv @@
// Iterative CORDIC rotator in degrees, one micro-rotation per cycle.
module drps_cordic
   import drps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  angle,
   output logic signed [31:0]  cos_out,
   output logic signed [31:0]  sin_out,
   output cordic_status_type   status
);

   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [31:0] dx, dy;

   // Shifted cross terms for this iteration
   assign dx = y_ff >>> iter_ff;
   assign dy = x_ff >>> iter_ff;

   // Load on start, rotate while busy, pulse done after the last iteration
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CORDIC_GAIN_Q30;
         y_in    = '0;
         z_in    = angle;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ATAN_DEG_Q24[iter_ff];
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ATAN_DEG_Q24[iter_ff];
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold the datapath, reset only control
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign cos_out     = x_ff;
   assign sin_out     = y_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ src/dead_reckoning_pose_step_unit.sv @@
// Top level of the dead reckoning pose step unit: sequencer, state and result register.
//
// Usage:
//   req_chan carries one step word (step_length, speed, turn_rate) per handshake;
//   rsp_chan returns one pose word (elapsed_time, heading_out, distance_out,
//   x_out, y_out) for every step word, in order. Both use valid/ready; a word
//   moves on a clock edge where both are high.
//   The unit works on one step at a time and drops req_chan.ready until the
//   pose word has been written into the output register, so a new step word
//   is taken only after the last one is through. The work is the 16-iteration
//   CORDIC rotator and single passes through the one shared 33x33 multiplier
//   (products, divide by 25 via reciprocal), plus repeated passes of heading
//   reduction by 360 degrees.
//   The output register parts the two sides: a finished pose word waits there
//   while the unit accepts and computes the next step. If the receiver still
//   stalls when the next pose word is ready, the unit holds it and stays not
//   ready until rsp_chan.ready frees the register.
//   Synchronous reset clears time, heading, distance and position to zero,
//   empties the output register and returns the sequencer to idle.
module dead_reckoning_pose_step_unit
   import drps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   drps_req_if.sink          req_chan,
   drps_rsp_if.source        rsp_chan
);

   drps_state_type state_ff, state_in;

   // Latched step word
   logic        [15:0] step_ff;
   logic signed [15:0] speed_ff;
   logic signed [15:0] turn_ff;

   // Pose accumulators
   logic        [31:0] time_acc_ff;
   logic signed [25:0] heading_acc_ff;
   logic        [31:0] distance_acc_ff;
   logic        [31:0] x_acc_ff;
   logic        [31:0] y_acc_ff;

   // Working registers
   logic signed [26:0]           h_ff;
   logic signed [26:0]           a_ff;
   logic signed [31:0]           p_ff;
   logic                         dist_neg_ff;
   logic                         x_neg_ff;
   logic                         y_neg_ff;
   logic                         flip_ff;
   logic        [DIVIDEND_W-1:0] nx_ff;
   logic        [DIVIDEND_W-1:0] ny_ff;

   // Result register
   logic               rsp_valid_ff;
   logic        [31:0] rsp_time_ff;
   logic signed [25:0] rsp_heading_ff;
   logic        [31:0] rsp_distance_ff;
   logic        [31:0] rsp_x_ff;
   logic        [31:0] rsp_y_ff;

   // Shared units
   mul_opnd_type       mul_a, mul_b;
   mul_prod_type       prod;
   logic        [65:0] prod_u, prod_mag;
   logic [QUOT_W-1:0]  quot;
   logic               cordic_start;
   logic signed [31:0] cordic_angle;
   logic signed [31:0] cordic_cos, cordic_sin;
   cordic_status_type  cordic_st;
   logic signed [32:0] cos_ext, sin_ext;
   logic signed [26:0] quad_angle;
   logic               quad_flip;

   logic accept;
   logic rsp_free;
   logic h_out_of_range;

   function automatic logic [31:0] apply_sign(input logic [QUOT_W-1:0] q, input logic neg);
      logic [31:0] w;
      w = {{(32 - QUOT_W){1'b0}}, q};
      return neg ? (~w + 32'd1) : w;
   endfunction

   drps_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   drps_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_angle),
      .cos_out (cordic_cos),
      .sin_out (cordic_sin),
      .status  (cordic_st)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // Magnitude of the product and the divide-by-25 quotient field
   assign prod_u   = $unsigned(prod);
   assign prod_mag = prod_u[65] ? (~prod_u + 66'd1) : prod_u;
   assign quot     = prod_u[DIV25_SHIFT + QUOT_W - 1:DIV25_SHIFT];

   assign h_out_of_range = (h_ff >= DEG_360) || (h_ff <= -DEG_360);

   // Fold a [-180,180] angle into [-90,90]
   always_comb begin
      quad_flip  = 1'b0;
      quad_angle = a_ff;
      priority if (a_ff > DEG_90) begin
         quad_angle = a_ff - DEG_180;
         quad_flip  = 1'b1;
      end else if (a_ff < -DEG_90) begin
         quad_angle = a_ff + DEG_180;
         quad_flip  = 1'b1;
      end else begin
         quad_angle = a_ff;
      end
   end

   assign cos_ext = {cordic_cos[31], cordic_cos};
   assign sin_ext = {cordic_sin[31], cordic_sin};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_TURN;
         ST_TURN:   state_in = ST_SPEED;
         ST_SPEED:  state_in = ST_DIST;
         ST_DIST:   state_in = ST_DACC;
         ST_DACC:   state_in = ST_MOD;
         ST_MOD:    if (!h_out_of_range) state_in = ST_FOLD;
         ST_FOLD:   state_in = ST_QUAD;
         ST_QUAD:   state_in = ST_CORDIC;
         ST_CORDIC: if (cordic_st.done) state_in = ST_MULX;
         ST_MULX:   state_in = ST_MULY;
         ST_MULY:   state_in = ST_DIVX;
         ST_DIVX:   state_in = ST_DIVY;
         ST_DIVY:   state_in = ST_YACC;
         ST_YACC:   state_in = ST_OUT;
         ST_OUT:    if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and shared unit operands
   always_comb begin
      req_chan.ready = 1'b0;
      mul_a          = '0;
      mul_b          = '0;
      cordic_start   = 1'b0;
      cordic_angle   = {quad_angle[23:0], 8'b0};
      unique case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_TURN: begin
            mul_a = {17'b0, step_ff};
            mul_b = {{17{turn_ff[15]}}, turn_ff};
         end
         ST_SPEED: begin
            mul_a = {17'b0, step_ff};
            mul_b = {{17{speed_ff[15]}}, speed_ff};
         end
         ST_DIST: begin
            mul_a = {11'b0, prod_mag[31:10]};
            mul_b = {10'b0, DIV25_MAGIC};
         end
         ST_QUAD: cordic_start = 1'b1;
         ST_MULX: begin
            mul_a = {p_ff[31], p_ff};
            mul_b = flip_ff ? -cos_ext : cos_ext;
         end
         ST_MULY: begin
            mul_a = {p_ff[31], p_ff};
            mul_b = flip_ff ? -sin_ext : sin_ext;
         end
         ST_DIVX: begin
            mul_a = {11'b0, nx_ff};
            mul_b = {10'b0, DIV25_MAGIC};
         end
         ST_DIVY: begin
            mul_a = {11'b0, ny_ff};
            mul_b = {10'b0, DIV25_MAGIC};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the pose accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         time_acc_ff     <= '0;
         heading_acc_ff  <= '0;
         distance_acc_ff <= '0;
         x_acc_ff        <= '0;
         y_acc_ff        <= '0;
      end else begin
         if (accept) begin
            time_acc_ff <= time_acc_ff + {16'b0, req_chan.step_length};
         end
         if (state_ff == ST_MOD && !h_out_of_range) begin
            heading_acc_ff <= h_ff[25:0];
         end
         if (state_ff == ST_DACC) begin
            distance_acc_ff <= distance_acc_ff + apply_sign(quot, dist_neg_ff);
         end
         if (state_ff == ST_YACC) begin
            y_acc_ff <= y_acc_ff + apply_sign(quot, y_neg_ff);
         end
         if (state_ff == ST_DIVY) begin
            x_acc_ff <= x_acc_ff + apply_sign(quot, x_neg_ff);
         end
      end
   end

   // Working datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff  <= req_chan.step_length;
         speed_ff <= req_chan.speed;
         turn_ff  <= req_chan.turn_rate;
      end
      unique case (state_ff)
         ST_SPEED: h_ff <= {heading_acc_ff[25], heading_acc_ff} + prod[32:6];
         ST_DIST: begin
            p_ff        <= prod[31:0];
            dist_neg_ff <= prod[65];
         end
         ST_MOD: begin
            priority if (h_ff >= DEG_360) begin
               h_ff <= h_ff - DEG_360;
            end else if (h_ff <= -DEG_360) begin
               h_ff <= h_ff + DEG_360;
            end else begin
               h_ff <= h_ff;
            end
         end
         ST_FOLD: begin
            priority if (h_ff > DEG_180) begin
               a_ff <= h_ff - DEG_360;
            end else if (h_ff < -DEG_180) begin
               a_ff <= h_ff + DEG_360;
            end else begin
               a_ff <= h_ff;
            end
         end
         ST_QUAD: flip_ff <= quad_flip;
         ST_MULY: begin
            nx_ff    <= prod_mag[61:40];
            x_neg_ff <= prod[65];
         end
         ST_DIVX: begin
            ny_ff    <= prod_mag[61:40];
            y_neg_ff <= prod[65];
         end
         default: h_ff <= h_ff;
      endcase
   end

   // Load the result register when free, drop valid when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_time_ff     <= time_acc_ff;
         rsp_heading_ff  <= heading_acc_ff;
         rsp_distance_ff <= distance_acc_ff;
         rsp_x_ff        <= x_acc_ff;
         rsp_y_ff        <= y_acc_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.elapsed_time = rsp_time_ff;
   assign rsp_chan.heading_out  = rsp_heading_ff;
   assign rsp_chan.distance_out = rsp_distance_ff;
   assign rsp_chan.x_out        = rsp_x_ff;
   assign rsp_chan.y_out        = rsp_y_ff;

   // Heading stays strictly inside one turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      (heading_acc_ff > -26'sd23592960) && (heading_acc_ff < 26'sd23592960))
      else $error("heading accumulator left the open 360 degree range");

   // Rotator is running or finishing whenever the sequencer waits on it
   a_cordic_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (cordic_st.busy || cordic_st.done))
      else $error("sequencer waits on an idle rotator");

   // A new pose word appears only out of the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result valid rose outside the output state");

endmodule

@@ sim/drps_checker.sv @@
// Pose predictor and in-order scoreboard for the dead reckoning pose step unit.
module drps_checker
   import drps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   drps_req_if  req_mon,
   drps_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);

   // Odometer divisor (100 * 2^8) and position divisor (100 * 2^38)
   localparam longint DIST_DIV = 64'sd25600;
   localparam longint POS_DIV  = 64'sd100 <<< 38;

   typedef struct packed {
      logic        [31:0] elapsed_time;
      logic signed [25:0] heading;
      logic signed [31:0] distance;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } pose_word_type;

   // Predicted pose state
   logic        [31:0] time_sum;
   logic signed [25:0] heading_sum;
   logic        [31:0] dist_sum;
   logic        [31:0] x_sum;
   logic        [31:0] y_sum;

   // Pose words still owed by the unit, oldest first
   pose_word_type pose_due [$];

   // Rotate the gain vector by z (2^-24 degree units); return cos and sin in Q2.30
   task automatic rotate_deg(input longint angle, output longint cos_q30,
                             output longint sin_q30);
      longint vx, vy, vz, dx, dy;
      vx = longint'(CORDIC_GAIN_Q30);
      vy = 0;
      vz = angle;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vz >= 0) begin
            vx = vx - dx;
            vy = vy + dy;
            vz = vz - longint'(ATAN_DEG_Q24[i]);
         end else begin
            vx = vx + dx;
            vy = vy - dy;
            vz = vz + longint'(ATAN_DEG_Q24[i]);
         end
      end
      cos_q30 = vx;
      sin_q30 = vy;
   endtask

   // Advance the pose state by one step word and return the pose it produces
   task automatic advance_pose(input logic [15:0] step_len, input logic signed [15:0] spd,
                               input logic signed [15:0] turn, output pose_word_type pose);
      longint st, h, a, p, c, s;
      bit     flip;
      st   = longint'(step_len);
      flip = 1'b0;

      time_sum = time_sum + 32'(st);

      // Heading: floor shift to Q16, then truncated remainder by 360 degrees
      h = longint'(heading_sum) + ((st * longint'(turn)) >>> 6);
      h = h % longint'(DEG_360);
      heading_sum = h[25:0];

      p = st * longint'(spd);
      dist_sum = dist_sum + 32'(p / DIST_DIV);

      // Fold the heading into [-90, 90] for the rotator
      a = h;
      if (a > longint'(DEG_180))
         a = a - longint'(DEG_360);
      else if (a < -longint'(DEG_180))
         a = a + longint'(DEG_360);
      if (a > longint'(DEG_90)) begin
         a = a - longint'(DEG_180);
         flip = 1'b1;
      end else if (a < -longint'(DEG_90)) begin
         a = a + longint'(DEG_180);
         flip = 1'b1;
      end
      rotate_deg(a * 256, c, s);
      if (flip) begin
         c = -c;
         s = -s;
      end
      x_sum = x_sum + 32'((p * c) / POS_DIV);
      y_sum = y_sum + 32'((p * s) / POS_DIV);

      pose.elapsed_time = time_sum;
      pose.heading      = heading_sum;
      pose.distance     = dist_sum;
      pose.x            = x_sum;
      pose.y            = y_sum;
   endtask

   function automatic int check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
      if (want === got)
         return 0;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
   endfunction

   // Retire pose words first, then predict for a newly taken step word
   always @(posedge clock) begin
      pose_word_type due, fresh;
      int            errs;
      errs = 0;
      if (reset) begin
         time_sum    = '0;
         heading_sum = '0;
         dist_sum    = '0;
         x_sum       = '0;
         y_sum       = '0;
         pose_due.delete();
         pending <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pose_due.size() == 0) begin
               $error("pose word returned with no step word outstanding");
               errs = 1;
            end else begin
               due  = pose_due.pop_front();
               errs += check_field("elapsed_time", due.elapsed_time, rsp_mon.elapsed_time);
               errs += check_field("heading_out", due.heading, rsp_mon.heading_out);
               errs += check_field("distance_out", due.distance, rsp_mon.distance_out);
               errs += check_field("x_out", due.x, rsp_mon.x_out);
               errs += check_field("y_out", due.y, rsp_mon.y_out);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_pose(req_mon.step_length, req_mon.speed, req_mon.turn_rate, fresh);
            pose_due.push_back(fresh);
         end
         pending <= pose_due.size();
         if (errs != 0)
            fail_count <= fail_count + errs;
      end
   end

endmodule

@@ sim/tb.sv @@
// Stimulus, handshake pacing and verdict for the dead reckoning pose step unit.
module tb;
   import drps_pkg::*;

   localparam int NUM_RANDOM  = 530;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 40;

   // Step that turns exactly 90 degrees at half rate or -180 degrees at full negative rate
   localparam logic [15:0]        QUARTER_STEP = 16'd23040;
   localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;

   logic clock;
   logic reset;
   logic steady;
   int   fail_count;
   int   pending;
   int   idle_cycles = 0;
   int   words_sent  = 0;
   int   words_back  = 0;

   drps_req_if step_chan();
   drps_rsp_if pose_chan();

   dead_reckoning_pose_step_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (step_chan),
      .rsp_chan (pose_chan)
   );

   drps_checker pose_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (step_chan),
      .rsp_mon    (pose_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, a few long ones; none while steady
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Field value biased toward the extremes
   function automatic logic [15:0] pick_field();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one step word after a random gap and hold it until taken
   task automatic send_step(input logic [15:0] step_len, input logic [15:0] spd,
                            input logic [15:0] turn);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         step_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      step_chan.valid       <= 1'b1;
      step_chan.step_length <= step_len;
      step_chan.speed       <= spd;
      step_chan.turn_rate   <= turn;
      @(posedge clock);
      while (!step_chan.ready)
         @(posedge clock);
   endtask

   // Hold off the sender until every pose word has come back
   task automatic drain_poses();
      step_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // Result side: random stalls on ready
   initial begin
      int stall;
      pose_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            pose_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pose_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Count words and end the run if nothing moves for too long
   always @(posedge clock) begin
      if (step_chan.valid && step_chan.ready)
         words_sent <= words_sent + 1;
      if (pose_chan.valid && pose_chan.ready)
         words_back <= words_back + 1;
      if (reset || (step_chan.valid && step_chan.ready) || (pose_chan.valid && pose_chan.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int kind;
      reset                 <= 1'b1;
      steady                <= 1'b0;
      step_chan.valid       <= 1'b0;
      step_chan.step_length <= '0;
      step_chan.speed       <= '0;
      step_chan.turn_rate   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Quarter turns: fold boundaries at +/-90, +/-180, +/-270 and back to zero
      repeat (4) send_step(QUARTER_STEP, 16'sd256, QUARTER_TURN);
      repeat (4) send_step(QUARTER_STEP / 2, -16'sd256, 16'sh8000);
      // A full negative turn in one step lands exactly on a multiple of 360
      send_step(QUARTER_STEP * 2, 16'sh7FFF, 16'sh8000);
      // Field extremes
      send_step(16'h0000, 16'h0000, 16'h0000);
      send_step(16'hFFFF, 16'sh7FFF, 16'sh7FFF);
      send_step(16'hFFFF, 16'sh8000, 16'sh8000);
      send_step(16'h0000, 16'sh7FFF, 16'sh8000);
      send_step(16'h0001, 16'sh0001, 16'sh0001);
      send_step(16'h0001, 16'shFFFF, 16'shFFFF);
      send_step(16'h8000, 16'sh5555, 16'shAAAA);
      send_step(16'hFFFF, 16'shFFFF, 16'sh0000);
      drain_poses();

      // Random steps, some of them exact quarter turns with random speed
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 150)
            steady <= 1'b1;
         if (n == 230)
            steady <= 1'b0;
         if (n % 128 == 127)
            drain_poses();
         kind = $urandom_range(0, 9);
         if (kind == 0)
            send_step(QUARTER_STEP, pick_field(),
                      $urandom_range(0, 1) ? QUARTER_TURN : -QUARTER_TURN);
         else
            send_step(pick_field(), pick_field(), pick_field());
      end

      // Wait for the last pose word, then a quiet tail for stray words
      drain_poses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d step words and checked %0d pose words,", words_sent, words_back);
      $display("with quarter-turn folds, wrap at 360, field extremes and random stalls.");
      if (fail_count == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ files.f @@
src/drps_pkg.sv
src/drps_if.sv
src/drps_mul.sv
src/drps_cordic.sv
src/dead_reckoning_pose_step_unit.sv
sim/drps_checker.sv
sim/tb.sv
